/* hw/rtl/rzb_pkg.sv */
`default_nettype none
package rzb_pkg;

  localparam int SYMBOLS    = 256;
  localparam int WINDOW_LEN = 64;

  localparam int TICK_W  = 32;
  localparam int SYMID_W = 8;
  localparam int PRICE_W = 24;
  localparam int MID_W   = PRICE_W + 1;
  localparam int BAND_W  = 12;
  localparam int CFG_IDX_W = 1;

  localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int WADDR_W = $clog2(SYMBOLS * WINDOW_LEN);
  localparam int SUM_W   = MID_W + SLOT_W;
  localparam int SQ_W    = 2 * MID_W + SLOT_W;
  localparam int WV_W    = SQ_W + SLOT_W;
  localparam int WLO_W   = 32;
  localparam int WHI_W   = WV_W - WLO_W;
  localparam int B2_W    = 2 * BAND_W;
  localparam int DD_W    = 2 * SUM_W;
  localparam int RHS_W   = WV_W + B2_W;

  localparam logic [BAND_W-1:0] ENTRY_BAND_RST = BAND_W'(512);
  localparam logic [BAND_W-1:0] EXIT_BAND_RST  = BAND_W'(128);

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BAND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_BAND  = CFG_IDX_W'(1);

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [1:0] {
    HOLD_FLAT  = 2'd0,
    HOLD_LONG  = 2'd1,
    HOLD_SHORT = 2'd2
  } hold_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
    logic [CNT_W-1:0]  fill;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        hold;
  } st_entry_t;

endpackage
`default_nettype wire

/* hw/rtl/rzb_quote_if.sv */
`default_nettype none
interface rzb_quote_if;
  logic                          valid;
  logic                          ready;
  logic [rzb_pkg::TICK_W-1:0]    tick_number;
  logic [rzb_pkg::SYMID_W-1:0]   symbol;
  logic [rzb_pkg::PRICE_W-1:0]   bid_price;
  logic [rzb_pkg::PRICE_W-1:0]   ask_price;

  modport source (output valid, tick_number, symbol, bid_price, ask_price, input ready);
  modport sink (input valid, tick_number, symbol, bid_price, ask_price, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rzb_order_if.sv */
`default_nettype none
interface rzb_order_if;
  logic                          valid;
  logic                          ready;
  logic [rzb_pkg::TICK_W-1:0]    order_tick;
  logic [rzb_pkg::SYMID_W-1:0]   order_symbol;
  logic                          order_side;
  logic [rzb_pkg::PRICE_W-1:0]   order_price;
  logic                          order_quantity;

  modport source (output valid, order_tick, order_symbol, order_side, order_price,
                  order_quantity, input ready);
  modport sink (input valid, order_tick, order_symbol, order_side, order_price,
                order_quantity, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rolling_zscore_band_signal.sv */
// channel   dir   handshake        payload
// in_quote  in    valid/ready      tick_number, symbol, bid_price, ask_price
// out_order out   valid/ready      order_tick, order_symbol, order_side, order_price, qty
// cfg       in    cfg_we           cfg_index, cfg_wdata (entry_band, exit_band)
//
// A request runs from accept through a read of the per-symbol state memory, a read of the
// mid ring memory, then a chain of multiplies; no new quote is accepted until it is done.
// Synchronous reset clears the per-symbol valid bits at once; no clearing pass.
// The order register holds a result while the next request is accepted; a second
// result waits in the decision step until the first is taken.
`default_nettype none
module rolling_zscore_band_signal (
  input  wire                              clk,
  input  wire                              rst_n,
  rzb_quote_if.sink                        in_quote,
  rzb_order_if.source                      out_order,
  input  wire                              cfg_we,
  input  wire [rzb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [rzb_pkg::BAND_W-1:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDST, S_RDWIN, S_UPD, S_W1, S_W2, S_M1, S_M2, S_SUM, S_DEC
  } state_t;

  state_t state_r;

  rzb_pkg::st_entry_t st_mem [rzb_pkg::SYMBOLS];
  logic [rzb_pkg::MID_W-1:0] win_mem [rzb_pkg::SYMBOLS * rzb_pkg::WINDOW_LEN];
  logic [rzb_pkg::SYMBOLS-1:0] st_vld_r;

  logic [rzb_pkg::BAND_W-1:0]  entry_r, exit_r;
  logic [rzb_pkg::TICK_W-1:0]  tick_r;
  logic [rzb_pkg::SYMID_W-1:0] symid_r;
  logic [rzb_pkg::SYM_W-1:0]   sidx_r;
  logic [rzb_pkg::PRICE_W-1:0] bid_r, ask_r;
  logic [rzb_pkg::MID_W-1:0]   m_r;

  rzb_pkg::st_entry_t st_rd_r;
  logic               st_rv_r;
  logic [rzb_pkg::MID_W-1:0]   win_rd_r;
  logic [rzb_pkg::WADDR_W-1:0] waddr_r;

  logic [rzb_pkg::SUM_W-1:0]   sum_r;
  logic [rzb_pkg::SQ_W-1:0]    sq_r;
  logic [rzb_pkg::CNT_W-1:0]   fill_r;
  logic [rzb_pkg::SLOT_W-1:0]  slot_r;
  logic [1:0]                  hold_r;
  logic [2*rzb_pkg::MID_W-1:0] mm_r, oo_r;
  logic [rzb_pkg::DD_W-1:0]    ss_r, dd_r;
  logic signed [rzb_pkg::SUM_W:0] d_r;
  logic [rzb_pkg::WV_W-1:0]    wv_r;
  logic [rzb_pkg::B2_W-1:0]    e2_r, x2_r;
  logic [rzb_pkg::WLO_W+rzb_pkg::B2_W-1:0] pe_lo_r, px_lo_r;
  logic [rzb_pkg::WHI_W+rzb_pkg::B2_W-1:0] pe_hi_r, px_hi_r;
  logic [rzb_pkg::RHS_W-1:0]   rhs_e_r, rhs_x_r, lhs_r;

  logic                        out_valid_r;
  logic [rzb_pkg::TICK_W-1:0]  out_tick_r;
  logic [rzb_pkg::SYMID_W-1:0] out_sym_r;
  logic                        out_side_r;
  logic [rzb_pkg::PRICE_W-1:0] out_price_r;

  rzb_pkg::st_entry_t          st_cur;
  logic [rzb_pkg::SLOT_W-1:0]  slot_fix;
  logic [rzb_pkg::WADDR_W-1:0] win_addr;
  logic                        win_full;
  logic [rzb_pkg::MID_W-1:0]   old_mid;
  logic [rzb_pkg::SUM_W-1:0]   nm, dabs;
  logic [rzb_pkg::WV_W-1:0]    nq;
  logic                        in_acc, sym_ok;
  logic                        emit, ready_win, can_out, out_push;
  logic                        side;
  logic [1:0]                  hold_nxt;

  assign in_quote.ready = (state_r == S_IDLE);
  assign in_acc = in_quote.valid && in_quote.ready;
  assign sym_ok = (int'(in_quote.symbol) < rzb_pkg::SYMBOLS);

  assign st_cur   = st_rv_r ? st_rd_r : '0;
  assign slot_fix = (int'(st_cur.slot) >= rzb_pkg::WINDOW_LEN) ? '0 : st_cur.slot;
  assign win_addr = rzb_pkg::WADDR_W'(rzb_pkg::WADDR_W'(sidx_r)
                    * rzb_pkg::WADDR_W'(rzb_pkg::WINDOW_LEN)) + rzb_pkg::WADDR_W'(slot_fix);
  assign win_full = (int'(fill_r) >= rzb_pkg::WINDOW_LEN);
  assign old_mid  = win_full ? win_rd_r : '0;
  assign nm   = rzb_pkg::SUM_W'(rzb_pkg::SUM_W'(m_r) * rzb_pkg::SUM_W'(rzb_pkg::WINDOW_LEN));
  assign nq   = rzb_pkg::WV_W'(rzb_pkg::WV_W'(sq_r) * rzb_pkg::WV_W'(rzb_pkg::WINDOW_LEN));
  assign dabs = d_r[rzb_pkg::SUM_W] ? rzb_pkg::SUM_W'(-d_r) : rzb_pkg::SUM_W'(d_r);

  always_comb begin
    emit     = 1'b0;
    side     = rzb_pkg::SIDE_BUY;
    hold_nxt = hold_r;
    ready_win = (int'(fill_r) >= rzb_pkg::WINDOW_LEN) && (wv_r != '0);
    if (ready_win) begin
      if (hold_r == rzb_pkg::HOLD_FLAT) begin
        if (!d_r[rzb_pkg::SUM_W] && lhs_r >= rhs_e_r) begin
          emit = 1'b1;
          side = rzb_pkg::SIDE_SELL;
          hold_nxt = rzb_pkg::HOLD_SHORT;
        end else if (d_r[rzb_pkg::SUM_W] && lhs_r >= rhs_e_r) begin
          emit = 1'b1;
          side = rzb_pkg::SIDE_BUY;
          hold_nxt = rzb_pkg::HOLD_LONG;
        end
      end else if (lhs_r <= rhs_x_r) begin
        emit = 1'b1;
        side = (hold_r == rzb_pkg::HOLD_LONG) ? rzb_pkg::SIDE_SELL : rzb_pkg::SIDE_BUY;
        hold_nxt = rzb_pkg::HOLD_FLAT;
      end
    end
    can_out = !out_valid_r || out_order.ready;
    out_push = (state_r == S_DEC) && emit && can_out;
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      st_rd_r <= st_mem[rzb_pkg::SYM_W'(in_quote.symbol)];
    end
    if (state_r == S_RDST) begin
      win_rd_r <= win_mem[win_addr];
    end
    if (state_r == S_RDWIN) begin
      win_mem[waddr_r] <= m_r;
    end
    if (state_r == S_DEC && (!emit || can_out)) begin
      st_mem[sidx_r] <= '{sum: sum_r, sq: sq_r, fill: fill_r, slot: slot_r, hold: hold_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_vld_r    <= '0;
      st_rv_r     <= 1'b0;
      entry_r     <= rzb_pkg::ENTRY_BAND_RST;
      exit_r      <= rzb_pkg::EXIT_BAND_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rzb_pkg::CFG_ENTRY_BAND: entry_r <= cfg_wdata;
          rzb_pkg::CFG_EXIT_BAND:  exit_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_order.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && sym_ok) begin
            tick_r  <= in_quote.tick_number;
            symid_r <= in_quote.symbol;
            sidx_r  <= rzb_pkg::SYM_W'(in_quote.symbol);
            bid_r   <= in_quote.bid_price;
            ask_r   <= in_quote.ask_price;
            m_r     <= rzb_pkg::MID_W'(in_quote.bid_price) + rzb_pkg::MID_W'(in_quote.ask_price);
            st_rv_r <= st_vld_r[rzb_pkg::SYM_W'(in_quote.symbol)];
            state_r <= S_RDST;
          end
        end
        S_RDST: begin
          sum_r   <= st_cur.sum;
          sq_r    <= st_cur.sq;
          fill_r  <= st_cur.fill;
          hold_r  <= st_cur.hold;
          slot_r  <= (int'(slot_fix) + 1 >= rzb_pkg::WINDOW_LEN) ? '0 : slot_fix + 1'b1;
          waddr_r <= win_addr;
          mm_r    <= m_r * m_r;
          state_r <= S_RDWIN;
        end
        S_RDWIN: begin
          oo_r    <= old_mid * old_mid;
          sum_r   <= sum_r - rzb_pkg::SUM_W'(old_mid) + rzb_pkg::SUM_W'(m_r);
          if (!win_full) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= S_UPD;
        end
        S_UPD: begin
          sq_r    <= sq_r - rzb_pkg::SQ_W'(oo_r) + rzb_pkg::SQ_W'(mm_r);
          state_r <= S_W1;
        end
        S_W1: begin
          ss_r    <= sum_r * sum_r;
          d_r     <= $signed({1'b0, nm}) - $signed({1'b0, sum_r});
          state_r <= S_W2;
        end
        S_W2: begin
          wv_r    <= nq - rzb_pkg::WV_W'(ss_r);
          dd_r    <= dabs * dabs;
          e2_r    <= entry_r * entry_r;
          x2_r    <= exit_r * exit_r;
          state_r <= S_M1;
        end
        S_M1: begin
          pe_lo_r <= wv_r[rzb_pkg::WLO_W-1:0] * e2_r;
          px_lo_r <= wv_r[rzb_pkg::WLO_W-1:0] * x2_r;
          state_r <= S_M2;
        end
        S_M2: begin
          pe_hi_r <= wv_r[rzb_pkg::WV_W-1:rzb_pkg::WLO_W] * e2_r;
          px_hi_r <= wv_r[rzb_pkg::WV_W-1:rzb_pkg::WLO_W] * x2_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          rhs_e_r <= {pe_hi_r, rzb_pkg::WLO_W'(0)} + rzb_pkg::RHS_W'(pe_lo_r);
          rhs_x_r <= {px_hi_r, rzb_pkg::WLO_W'(0)} + rzb_pkg::RHS_W'(px_lo_r);
          lhs_r   <= rzb_pkg::RHS_W'({dd_r, 16'h0000});
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (!emit || can_out) begin
            st_vld_r[sidx_r] <= 1'b1;
            state_r <= S_IDLE;
            if (emit) begin
              out_tick_r  <= tick_r;
              out_sym_r   <= symid_r;
              out_side_r  <= side;
              out_price_r <= side ? bid_r : ask_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_order.valid          = out_valid_r;
  assign out_order.order_tick     = out_tick_r;
  assign out_order.order_symbol   = out_sym_r;
  assign out_order.order_side     = out_side_r;
  assign out_order.order_price    = out_price_r;
  assign out_order.order_quantity = 1'b1;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDWIN |-> int'(fill_r) <= rzb_pkg::WINDOW_LEN)
    else $error("fill count beyond window");

  a_var_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W2 |-> rzb_pkg::WV_W'(ss_r) <= nq)
    else $error("negative window variance");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC && emit && can_out) |=> out_valid_r)
    else $error("order lost");

  a_hold_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEC |-> hold_r != 2'd3)
    else $error("bad position code");

endmodule
`default_nettype wire
